### hw/rtl/alts_pkg.sv
// Shared types and constants of the auto-launch throttle sequencer.
package alts_pkg;

    // Flight state codes as seen on the result word
    localparam logic [2:0] FS_LOCKED  = 3'd0;
    localparam logic [2:0] FS_STANDBY = 3'd1;
    localparam logic [2:0] FS_CLIMB   = 3'd2;
    localparam logic [2:0] FS_DESCEND = 3'd3;
    localparam logic [2:0] FS_LAND    = 3'd4;
    localparam logic [2:0] FS_DONE    = 3'd5;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STICK_MIN_CHECK  = 3'd0,
        CFG_ONE_G_SCALE      = 3'd1,
        CFG_CLIMB_THROTTLE   = 3'd2,
        CFG_DESCEND_THROTTLE = 3'd3,
        CFG_LAND_THROTTLE    = 3'd4,
        CFG_CLIMB_TICKS      = 3'd5,
        CFG_DESCEND_TICKS    = 3'd6,
        CFG_LAND_TICKS       = 3'd7
    } cfg_idx_t;

    // Pitch forced on a switch launch
    localparam logic signed [3:0] LAUNCH_PITCH = -4'sd5;

    // Throw arithmetic: 10*acc against 17*g, increment = diff/200 clamped to 1000
    localparam int unsigned  THROW_CLAMP_DIFF = 200000;
    localparam logic [9:0]   EXTRA_MAX        = 10'd1000;
    // floor(x/25) = (x*5243) >> 17, exact for x < 25000
    localparam logic [12:0]  DIV25_MUL        = 13'd5243;
    localparam int unsigned  DIV25_SHIFT      = 17;

    typedef struct packed {
        logic [10:0] stick_min_check;
        logic [14:0] one_g_scale;
        logic [10:0] climb_throttle;
        logic [10:0] descend_throttle;
        logic [10:0] land_throttle;
        logic [10:0] climb_ticks;
        logic [10:0] descend_ticks;
        logic [10:0] land_ticks;
    } cfg_t;

    typedef struct packed {
        logic               armed;
        logic [10:0]        aux_switch;
        logic [10:0]        throttle_stick;
        logic [10:0]        throttle_command;
        logic signed [15:0] accel_z;
    } in_word_t;

    typedef struct packed {
        logic [2:0]        flight_state;
        logic [10:0]       throttle_out;
        logic              attitude_override;
        logic signed [3:0] pitch_override;
        logic              clear_integrators;
    } out_word_t;

endpackage

### hw/rtl/alts_cfg_regs.sv
// Configuration register file of the auto-launch throttle sequencer.
module alts_cfg_regs import alts_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stick_min_check  <= 11'd1100;
            cfg_reg.one_g_scale      <= 15'd4096;
            cfg_reg.climb_throttle   <= 11'd1750;
            cfg_reg.descend_throttle <= 11'd1500;
            cfg_reg.land_throttle    <= 11'd1650;
            cfg_reg.climb_ticks      <= 11'd1000;
            cfg_reg.descend_ticks    <= 11'd700;
            cfg_reg.land_ticks       <= 11'd350;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_STICK_MIN_CHECK:  cfg_reg.stick_min_check  <= cfg_wdata[10:0];
                CFG_ONE_G_SCALE:      cfg_reg.one_g_scale      <= cfg_wdata;
                CFG_CLIMB_THROTTLE:   cfg_reg.climb_throttle   <= cfg_wdata[10:0];
                CFG_DESCEND_THROTTLE: cfg_reg.descend_throttle <= cfg_wdata[10:0];
                CFG_LAND_THROTTLE:    cfg_reg.land_throttle    <= cfg_wdata[10:0];
                CFG_CLIMB_TICKS:      cfg_reg.climb_ticks      <= cfg_wdata[10:0];
                CFG_DESCEND_TICKS:    cfg_reg.descend_ticks    <= cfg_wdata[10:0];
                CFG_LAND_TICKS:       cfg_reg.land_ticks       <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/alts_tick.sv
// Per-tick sequencer: flight state, phase counter, throw extension and result register.
module alts_tick import alts_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  in_word_t  in_word,
    input  cfg_t      cfg,
    output out_word_t res_word
);

    typedef enum logic [2:0] {
        S_LOCKED  = FS_LOCKED,
        S_STANDBY = FS_STANDBY,
        S_CLIMB   = FS_CLIMB,
        S_DESCEND = FS_DESCEND,
        S_LAND    = FS_LAND,
        S_DONE    = FS_DONE
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [11:0] phase_reg, phase_next;
    logic [9:0]  extra_reg, extra_next;
    out_word_t   res_reg, res_next;

    // throw detection and time extension
    logic signed [20:0] acc_ext, scaled, limit, diff;
    logic [19:0]        limit_u;
    logic               throw_seen;
    logic [18:0]        diff_u;
    logic [14:0]        diff_div8;
    logic [27:0]        quot_prod;
    logic [9:0]         throw_extra;

    always_comb begin
        acc_ext    = 21'(in_word.accel_z);
        scaled     = acc_ext * 21'sd10;
        limit_u    = 20'(cfg.one_g_scale) * 20'd17;
        limit      = $signed({1'b0, limit_u});
        diff       = scaled - limit;
        throw_seen = scaled > limit;
        diff_u     = diff[18:0];
        diff_div8  = diff_u[17:3];
        quot_prod  = 28'(diff_div8) * 28'(DIV25_MUL);
        if (32'(diff_u) >= THROW_CLAMP_DIFF) begin
            throw_extra = EXTRA_MAX;
        end else begin
            throw_extra = quot_prod[DIV25_SHIFT +: 10];
        end
    end

    logic              forced;
    logic              switch_launch;
    logic [10:0]       thr;
    logic [12:0]       phase_inc;
    logic [12:0]       phase_lim;
    logic              smc_aux_lt, smc_aux_gt, smc_stick_lt, smc_stick_gt;

    always_comb begin
        smc_aux_lt    = in_word.aux_switch < cfg.stick_min_check;
        smc_aux_gt    = in_word.aux_switch > cfg.stick_min_check;
        smc_stick_lt  = in_word.throttle_stick < cfg.stick_min_check;
        smc_stick_gt  = in_word.throttle_stick > cfg.stick_min_check;

        mode_next     = mode_reg;
        phase_next    = phase_reg;
        extra_next    = extra_reg;
        forced        = 1'b0;
        switch_launch = 1'b0;

        // outer rules
        case (mode_reg)
            S_LOCKED: begin
                if (in_word.armed && smc_aux_lt) mode_next = S_STANDBY;
            end
            S_STANDBY: begin
                // disarm drops to locked, but a launch in the same tick still wins
                if (!in_word.armed) mode_next = S_LOCKED;
                if (throw_seen) begin
                    mode_next  = S_CLIMB;
                    phase_next = '0;
                    forced     = 1'b1;
                    extra_next = throw_extra;
                end else if (smc_aux_gt) begin
                    mode_next     = S_CLIMB;
                    phase_next    = '0;
                    forced        = 1'b1;
                    switch_launch = 1'b1;
                    extra_next    = '0;
                end
            end
            S_CLIMB, S_DESCEND, S_LAND: forced = 1'b1;
            S_DONE: begin
                if (smc_aux_gt) mode_next = S_LOCKED;
            end
            default: ;
        endcase

        // manual takeover
        if (mode_next != S_DONE && mode_next != S_LOCKED && smc_stick_gt) mode_next = S_DONE;

        // inner rules
        phase_inc = {1'b0, phase_next} + 13'd1;
        phase_lim = '0;
        case (mode_next)
            S_CLIMB: begin
                thr        = cfg.climb_throttle;
                phase_lim  = 13'(cfg.climb_ticks) + 13'(extra_next);
                phase_next = phase_inc[11:0];
                if (phase_inc > phase_lim) begin
                    mode_next  = S_DESCEND;
                    phase_next = '0;
                end
            end
            S_DESCEND: begin
                thr        = cfg.descend_throttle;
                phase_lim  = 13'(cfg.descend_ticks) + 13'(extra_next);
                phase_next = phase_inc[11:0];
                if (phase_inc > phase_lim) begin
                    mode_next  = S_LAND;
                    phase_next = '0;
                end
            end
            S_LAND: begin
                thr        = cfg.land_throttle;
                phase_lim  = 13'(cfg.land_ticks);
                phase_next = phase_inc[11:0];
                if (phase_inc > phase_lim) begin
                    mode_next  = S_DONE;
                    phase_next = '0;
                end
            end
            default: thr = in_word.throttle_command;
        endcase

        res_next.flight_state      = mode_next;
        res_next.throttle_out      = thr;
        res_next.attitude_override = forced;
        res_next.pitch_override    = switch_launch ? LAUNCH_PITCH : 4'sd0;
        res_next.clear_integrators = mode_next != S_CLIMB && mode_next != S_DESCEND
                                     && smc_stick_lt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= S_LOCKED;
            phase_reg <= '0;
            extra_reg <= '0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            extra_reg <= extra_next;
            res_reg   <= res_next;
        end
    end

    assign res_word = res_reg;

endmodule

### hw/rtl/auto_launch_throttle_sequencer.sv
// Top level of the auto-launch throttle sequencer: handshake, word registers, assertions.
//
// One input word is one control tick. The block takes a word in every cycle when the
// result side keeps up, and each word gives exactly one result word: the word is held in
// the input register while the tick logic works on it, and the result register catches
// the outcome when the result side has room. Sustained rate is one word per cycle while
// m_ready keeps up; it is set by the update of the flight state, phase counter and throw
// extension, which every tick reads and writes. s_ready is low only while a word sits in
// the input register and the result register holds a word that m_ready does not take.
// Configuration writes are registered and must be made while no word is in flight.
module auto_launch_throttle_sequencer import alts_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data
);

    cfg_t      cfg;
    logic      in_valid_reg, in_valid_next;
    in_word_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    logic      advance;   // result register free or emptied this cycle
    logic      fire;      // tick logic consumes the input register

    alts_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = (in_valid_reg && !advance) || (s_valid && s_ready);
        out_valid_next = fire || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (s_valid && s_ready) in_data_reg <= s_data;
        end
    end

    alts_tick u_tick (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .in_word  (in_data_reg),
        .cfg      (cfg),
        .res_word (m_data)
    );

    assign m_valid = out_valid_reg;

    // a held input word is not overwritten while the tick logic is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input word lost while stalled");

    // forced pitch only comes with forced attitude
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.pitch_override != 4'sd0 |-> m_data.attitude_override)
        else $error("pitch override without attitude override");

    // integrators are never cleared mid-climb or mid-descent
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.clear_integrators |->
            m_data.flight_state != FS_CLIMB && m_data.flight_state != FS_DESCEND)
        else $error("integrator clear in powered phase");

    // each consumed tick yields a result word in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("result word missing after tick");

endmodule

### tb/tb_auto_launch_throttle_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench of the auto-launch throttle sequencer: scripted and random flights.

import alts_pkg::*;

// Tick-accurate model of the sequencer plus the queue of words it has predicted.
class flight_scoreboard;
    cfg_t       regs;
    logic [2:0] mode;
    int         phase_cnt;
    int         extra;
    out_word_t  predicted_words[$];
    int         errors;
    int         ticks;
    int         results;
    int         throws;
    int         clamped;
    int         switch_launches;
    int         takeovers;
    int         landings;

    function new();
        regs.stick_min_check  = 11'd1100;
        regs.one_g_scale      = 15'd4096;
        regs.climb_throttle   = 11'd1750;
        regs.descend_throttle = 11'd1500;
        regs.land_throttle    = 11'd1650;
        regs.climb_ticks      = 11'd1000;
        regs.descend_ticks    = 11'd700;
        regs.land_ticks       = 11'd350;
        mode      = FS_LOCKED;
        phase_cnt = 0;
        extra     = 0;
    endfunction

    function void write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_STICK_MIN_CHECK:  regs.stick_min_check  = v[10:0];
            CFG_ONE_G_SCALE:      regs.one_g_scale      = v;
            CFG_CLIMB_THROTTLE:   regs.climb_throttle   = v[10:0];
            CFG_DESCEND_THROTTLE: regs.descend_throttle = v[10:0];
            CFG_LAND_THROTTLE:    regs.land_throttle    = v[10:0];
            CFG_CLIMB_TICKS:      regs.climb_ticks      = v[10:0];
            CFG_DESCEND_TICKS:    regs.descend_ticks    = v[10:0];
            CFG_LAND_TICKS:       regs.land_ticks       = v[10:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return predicted_words.size();
    endfunction

    // One control tick: outer state rules, then takeover, throttle and phase counter.
    function void note_tick(in_word_t w);
        int                acc;
        int                scaled;
        int                lim;
        int                inc;
        logic              forced;
        logic signed [3:0] pitch;
        logic [10:0]       thr;
        out_word_t         r;
        ticks++;
        acc    = $signed(w.accel_z);
        forced = 1'b0;
        pitch  = '0;
        case (mode)
            FS_LOCKED: begin
                if (w.armed && w.aux_switch < regs.stick_min_check)
                    mode = FS_STANDBY;
            end
            FS_STANDBY: begin
                scaled = 10 * acc;
                lim    = 17 * int'(regs.one_g_scale);
                // disarming drops to locked but a launch in the same tick still wins
                if (!w.armed)
                    mode = FS_LOCKED;
                if (scaled > lim) begin
                    inc = (scaled - lim) / 200;
                    if (inc > 1000) begin
                        inc = 1000;
                        clamped++;
                    end
                    mode      = FS_CLIMB;
                    phase_cnt = 0;
                    forced    = 1'b1;
                    extra     = inc;
                    throws++;
                end else if (w.aux_switch > regs.stick_min_check) begin
                    mode      = FS_CLIMB;
                    phase_cnt = 0;
                    forced    = 1'b1;
                    pitch     = LAUNCH_PITCH;
                    extra     = 0;
                    switch_launches++;
                end
            end
            FS_CLIMB, FS_DESCEND, FS_LAND: forced = 1'b1;
            FS_DONE: begin
                if (w.aux_switch > regs.stick_min_check)
                    mode = FS_LOCKED;
            end
            default: ;
        endcase

        if (mode != FS_DONE && mode != FS_LOCKED && w.throttle_stick > regs.stick_min_check) begin
            mode = FS_DONE;
            takeovers++;
        end

        thr = w.throttle_command;
        case (mode)
            FS_CLIMB: begin
                thr = regs.climb_throttle;
                phase_cnt++;
                if (phase_cnt > int'(regs.climb_ticks) + extra) begin
                    mode      = FS_DESCEND;
                    phase_cnt = 0;
                end
            end
            FS_DESCEND: begin
                thr = regs.descend_throttle;
                phase_cnt++;
                if (phase_cnt > int'(regs.descend_ticks) + extra) begin
                    mode      = FS_LAND;
                    phase_cnt = 0;
                end
            end
            FS_LAND: begin
                thr = regs.land_throttle;
                phase_cnt++;
                if (phase_cnt > int'(regs.land_ticks)) begin
                    mode      = FS_DONE;
                    phase_cnt = 0;
                    landings++;
                end
            end
            default: ;
        endcase
        phase_cnt = phase_cnt & 'hFFF;

        r.flight_state      = mode;
        r.throttle_out      = thr;
        r.attitude_override = forced;
        r.pitch_override    = pitch;
        r.clear_integrators = mode != FS_DESCEND && mode != FS_CLIMB
                              && w.throttle_stick < regs.stick_min_check;
        predicted_words.push_back(r);
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 20)
            $display("MISMATCH at result %0d: %s", results, msg);
    endtask

    task check_result(out_word_t got);
        out_word_t want;
        results++;
        if (predicted_words.size() == 0) begin
            report($sformatf("result word %h with nothing outstanding", got));
            return;
        end
        want = predicted_words.pop_front();
        if (got.flight_state !== want.flight_state)
            report($sformatf("flight_state %0d, expected %0d",
                             got.flight_state, want.flight_state));
        if (got.throttle_out !== want.throttle_out)
            report($sformatf("throttle_out %0d, expected %0d",
                             got.throttle_out, want.throttle_out));
        if (got.attitude_override !== want.attitude_override)
            report($sformatf("attitude_override %b, expected %b",
                             got.attitude_override, want.attitude_override));
        if (got.pitch_override !== want.pitch_override)
            report($sformatf("pitch_override %0d, expected %0d",
                             got.pitch_override, want.pitch_override));
        if (got.clear_integrators !== want.clear_integrators)
            report($sformatf("clear_integrators %b, expected %b",
                             got.clear_integrators, want.clear_integrators));
    endtask
endclass

module tb_auto_launch_throttle_sequencer;

    // The watchdog limit lies many times above the slowest honest run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 204;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_word_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_word_t             m_data;

    flight_scoreboard sb;
    int               takeover_odds = 100;  // 1-in-N chance per flight tick of a stick takeover
    bit               fast_src      = 1'b0; // sender offers back to back
    bit               fast_sink     = 1'b0; // receiver never stalls
    bit               hold_req      = 1'b0; // receiver to hold off for a long stretch
    int               cycles        = 0;

    auto_launch_throttle_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // RC level strictly above a threshold; from 2000 up only out-of-range levels remain
    function automatic logic [10:0] level_above(logic [10:0] th);
        return 11'((th < 11'd2000) ? $urandom_range(th + 1, 2000) : $urandom_range(2001, 2047));
    endfunction

    // RC level strictly below a threshold; at 1000 only out-of-range levels remain
    function automatic logic [10:0] level_below(logic [10:0] th);
        return 11'((th > 11'd1000) ? $urandom_range(1000, th - 1) : $urandom_range(0, th - 1));
    endfunction

    function automatic in_word_t word_of(bit armed, int aux, int stick, int cmd, int acc);
        in_word_t w;
        w.armed            = armed;
        w.aux_switch       = 11'(aux);
        w.throttle_stick   = 11'(stick);
        w.throttle_command = 11'(cmd);
        w.accel_z          = 16'(acc);
        return w;
    endfunction

    // Next word, steered by the predicted flight state so that most words move a flight
    // along: arm, launch, let the phases run out, land, reset. A few words are pure noise.
    function automatic in_word_t next_word();
        in_word_t    w;
        logic [10:0] th;
        int          lo_throw;  // smallest reading that counts as a throw
        int          a;
        int          r;
        th       = sb.regs.stick_min_check;
        lo_throw = (17 * int'(sb.regs.one_g_scale)) / 10 + 1;
        r        = $urandom_range(0, 99);

        w.armed            = 1'b1;
        w.aux_switch       = 11'($urandom_range(1000, 2000));
        w.throttle_stick   = level_below(th);
        w.throttle_command = 11'($urandom_range(1000, 2000));
        // calm reading, now and then sitting right on the throw threshold
        a = $urandom_range(0, lo_throw + 32767) - 32768;
        if ($urandom_range(0, 4) == 0)
            a = lo_throw - 1;
        w.accel_z = 16'(a);

        if (r < 7) begin
            w.armed            = 1'($urandom);
            w.aux_switch       = 11'($urandom);
            w.throttle_stick   = 11'($urandom);
            w.throttle_command = 11'($urandom);
            w.accel_z          = 16'($urandom);
            return w;
        end

        case (sb.mode)
            FS_LOCKED: begin
                if (r < 80)
                    w.aux_switch = level_below(th);
                else
                    w.armed = 1'($urandom);
            end
            FS_STANDBY: begin
                if (r < 20)
                    w.armed = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    // mostly gentle throws so the extension stays short
                    a = lo_throw + $urandom_range(0, 300);
                    if ($urandom_range(0, 4) == 0)
                        a = $urandom_range(lo_throw, 32767);
                    w.accel_z = 16'((a > 32767) ? 32767 : a);
                end else if (r < 75) begin
                    w.aux_switch = level_above(th);
                end else begin
                    w.aux_switch = $urandom_range(0, 1) ? th : level_below(th);
                end
            end
            FS_CLIMB, FS_DESCEND, FS_LAND: begin
                w.aux_switch = 11'($urandom);
                w.accel_z    = 16'($urandom);
                if ($urandom_range(1, takeover_odds) == 1)
                    w.throttle_stick = level_above(th);
                else if (r < 15)
                    w.throttle_stick = th;
            end
            FS_DONE: begin
                if (r < 40)
                    w.aux_switch = level_above(th);
                else if (r < 55)
                    w.aux_switch = th;
                w.throttle_stick = $urandom_range(0, 1) ? level_above(th) : level_below(th);
            end
            default: ;
        endcase
        return w;
    endfunction

    // Offer one word, hold it until taken, then idle for the given number of cycles.
    task automatic send_word(input in_word_t w, input int gap);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(w);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int n;
        forever begin
            n = fast_sink ? 0 : $urandom_range(0, 3);
            if (hold_req) begin
                // long enough to fill both word registers and back-pressure the sender
                n        = 80;
                hold_req = 1'b0;
            end
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Timed out after %0d cycles, %0d words outstanding", cycles, sb.pending());
        $display("tb_auto_launch_throttle_sequencer failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        in_word_t              script[$];
        cfg_t                  setting;
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] val;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Scripted flights at the reset settings (threshold 1100, throw above reading 6963).
        script.push_back(word_of(0, 1000, 2000, 1000, 0));      // locked ignores the stick
        script.push_back(word_of(1, 2000, 1000, 2000, -32768)); // switch up, stays locked
        script.push_back(word_of(1, 1100, 1100, 1500, 0));      // switch on threshold, locked
        script.push_back(word_of(1, 1099, 1000, 1234, 100));    // to standby
        script.push_back(word_of(1, 1100, 1100, 1000, 6963));   // just short of a throw
        script.push_back(word_of(1, 1000, 1000, 1000, 6964));   // weakest throw, no extension
        script.push_back(word_of(1, 2000, 1100, 1000, 32767));  // stick on threshold: no takeover
        script.push_back(word_of(0, 2047, 2047, 2047, -1));     // manual takeover to done
        script.push_back(word_of(1, 1100, 1000, 0, 0));         // done holds, command passes
        script.push_back(word_of(1, 1101, 1000, 2000, 0));      // switch up: back to locked
        script.push_back(word_of(1, 1000, 1000, 1000, 0));      // standby
        script.push_back(word_of(0, 2000, 1000, 1000, -32768)); // disarm and switch launch together
        script.push_back(word_of(1, 1000, 1000, 1000, 0));      // climbing
        script.push_back(word_of(1, 1000, 1101, 1000, 0));      // takeover
        script.push_back(word_of(1, 2000, 1000, 1000, 0));      // locked
        script.push_back(word_of(1, 0, 1000, 1000, 0));         // standby from a low raw level
        script.push_back(word_of(0, 1000, 1000, 1000, 0));      // disarm with no launch
        script.push_back(word_of(1, 1000, 1000, 1000, 0));      // standby
        script.push_back(word_of(1, 1000, 2000, 1000, 0));      // takeover straight from standby
        script.push_back(word_of(1, 2000, 1000, 1000, 0));      // locked
        script.push_back(word_of(1, 1000, 1000, 1000, 0));      // standby
        script.push_back(word_of(1, 1000, 1000, 1000, 32767));  // hardest throw, extension clamped
        script.push_back(word_of(1, 1000, 1000, 1000, 0));      // climbing
        script.push_back(word_of(1, 1000, 2000, 1000, 0));      // takeover
        script.push_back(word_of(1, 2000, 0, 1000, 0));         // locked, integrators cleared
        foreach (script[k])
            send_word(script[k], $urandom_range(0, 3));

        for (int ph = 1; ph <= 7; ph++) begin
            s_valid <= 1'b0;
            wait_drained();

            case (ph)
                1: setting = '{11'd1000, 15'd256, 11'd1000, 11'd1000, 11'd1000,
                               11'd1, 11'd1, 11'd1};
                2: setting = '{11'd2000, 15'd16384, 11'd2000, 11'd2000, 11'd2000,
                               11'd2047, 11'd2047, 11'd2047};
                7: setting = '{11'd1100, 15'd4096, 11'd1750, 11'd1500, 11'd1650,
                               11'd1000, 11'd700, 11'd350};
                default: begin
                    setting.stick_min_check  = 11'($urandom_range(1000, 2000));
                    setting.one_g_scale      = 15'($urandom_range(0, 1) ?
                                                   $urandom_range(256, 2048) :
                                                   $urandom_range(256, 16384));
                    setting.climb_throttle   = 11'($urandom_range(1000, 2000));
                    setting.descend_throttle = 11'($urandom_range(1000, 2000));
                    setting.land_throttle    = 11'($urandom_range(1000, 2000));
                    setting.climb_ticks      = 11'($urandom_range(0, 3) == 0 ?
                                                   $urandom_range(1, 300) : $urandom_range(1, 16));
                    setting.descend_ticks    = 11'($urandom_range(1, 16));
                    setting.land_ticks       = 11'($urandom_range(1, 16));
                end
            endcase

            // all eight registers, one per cycle, while nothing is in flight
            cfg_we <= 1'b1;
            for (int k = 0; k < 8; k++) begin
                idx = cfg_idx_t'(k);
                case (idx)
                    CFG_STICK_MIN_CHECK:  val = 15'(setting.stick_min_check);
                    CFG_ONE_G_SCALE:      val = setting.one_g_scale;
                    CFG_CLIMB_THROTTLE:   val = 15'(setting.climb_throttle);
                    CFG_DESCEND_THROTTLE: val = 15'(setting.descend_throttle);
                    CFG_LAND_THROTTLE:    val = 15'(setting.land_throttle);
                    CFG_CLIMB_TICKS:      val = 15'(setting.climb_ticks);
                    CFG_DESCEND_TICKS:    val = 15'(setting.descend_ticks);
                    default:              val = 15'(setting.land_ticks);
                endcase
                cfg_index <= idx;
                cfg_wdata <= val;
                @(posedge aclk);
                sb.write_register(idx, val);
            end
            cfg_we <= 1'b0;

            // long phases need takeovers more often to keep flights from eating the run
            takeover_odds = (ph == 2 || ph == 7) ? 30 : 100;
            fast_src      = (ph == 1 || ph == 5);
            fast_sink     = (ph == 2 || ph == 5);

            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (ph == 3 && i == 50)
                    hold_req = 1'b1;
                if (ph == 4 && i == 100) begin
                    // sender pauses until every outstanding word has come back
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    wait_drained();
                end
                send_word(next_word(), fast_src ? 0 : $urandom_range(0, 3));
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);

        $display("Run: %0d ticks over 8 register settings, %0d throw launches (%0d clamped),",
                 sb.ticks, sb.throws, sb.clamped);
        $display("     %0d switch launches, %0d stick takeovers, %0d full landings, %0d mismatches",
                 sb.switch_launches, sb.takeovers, sb.landings, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_auto_launch_throttle_sequencer passed");
        else
            $display("tb_auto_launch_throttle_sequencer failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/alts_pkg.sv
hw/rtl/alts_cfg_regs.sv
hw/rtl/alts_tick.sv
hw/rtl/auto_launch_throttle_sequencer.sv
tb/tb_auto_launch_throttle_sequencer.sv
